// ===== design/aes_pkg.sv =====
// ---------------------------------------------------------------------------
// aes_pkg
// Shared types, codes, S-box tables and round functions for the AES-256
// CBC core.
// ---------------------------------------------------------------------------
package aes_pkg;

	localparam int unsigned NUM_KEYS = 15;
	localparam logic [3:0] LAST_KEY = 4'd14;

	// configuration register indexes
	localparam logic [2:0] CFG_KEY0 = 3'd0;
	localparam logic [2:0] CFG_KEY1 = 3'd1;
	localparam logic [2:0] CFG_KEY2 = 3'd2;
	localparam logic [2:0] CFG_KEY3 = 3'd3;
	localparam logic [2:0] CFG_IV0  = 3'd4;
	localparam logic [2:0] CFG_IV1  = 3'd5;
	localparam logic [2:0] CFG_DEC  = 3'd6;

	// datapath operations
	localparam logic [2:0] OP_NONE   = 3'd0;
	localparam logic [2:0] OP_EXPAND = 3'd1;
	localparam logic [2:0] OP_LOAD   = 3'd2;
	localparam logic [2:0] OP_ADDKEY = 3'd3;
	localparam logic [2:0] OP_ROUND  = 3'd4;
	localparam logic [2:0] OP_FINISH = 3'd5;

	typedef struct packed {
		logic [2:0] op;
		logic [3:0] idx;     // expansion step
		logic [3:0] rd_idx;  // round key to fetch for next cycle
		logic       rd_en;
		logic       last;    // final round
	} cmd_t;

	typedef struct packed {
		logic decrypt;
		logic key_wr;
	} stat_t;

	localparam logic [7:0] SBOX [256] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	localparam logic [7:0] INV_SBOX [256] = '{
		8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
		8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
		8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
		8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
		8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
		8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
		8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
		8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
		8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
		8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
		8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
		8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
		8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
		8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
		8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
		8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
	};

	function automatic logic [7:0] xtime(input logic [7:0] a);
		return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [31:0] mix_col(input logic [31:0] w);
		logic [7:0] a0, a1, a2, a3;
		a0 = w[31:24]; a1 = w[23:16]; a2 = w[15:8]; a3 = w[7:0];
		return {xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3,
			a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3,
			a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3,
			xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3)};
	endfunction

	function automatic logic [7:0] gm9(input logic [7:0] a);
		return xtime(xtime(xtime(a))) ^ a;
	endfunction
	function automatic logic [7:0] gm11(input logic [7:0] a);
		return xtime(xtime(xtime(a))) ^ xtime(a) ^ a;
	endfunction
	function automatic logic [7:0] gm13(input logic [7:0] a);
		return xtime(xtime(xtime(a))) ^ xtime(xtime(a)) ^ a;
	endfunction
	function automatic logic [7:0] gm14(input logic [7:0] a);
		return xtime(xtime(xtime(a))) ^ xtime(xtime(a)) ^ xtime(a);
	endfunction

	function automatic logic [31:0] inv_mix_col(input logic [31:0] w);
		logic [7:0] a0, a1, a2, a3;
		a0 = w[31:24]; a1 = w[23:16]; a2 = w[15:8]; a3 = w[7:0];
		return {gm14(a0) ^ gm11(a1) ^ gm13(a2) ^ gm9(a3),
			gm9(a0) ^ gm14(a1) ^ gm11(a2) ^ gm13(a3),
			gm13(a0) ^ gm9(a1) ^ gm14(a2) ^ gm11(a3),
			gm11(a0) ^ gm13(a1) ^ gm9(a2) ^ gm14(a3)};
	endfunction

	// byte n of a block, byte 0 in the top bits
	function automatic logic [7:0] get_byte(input logic [127:0] s, input int n);
		return s[127-8*n -: 8];
	endfunction

	function automatic logic [127:0] enc_round(input logic [127:0] s,
			input logic [127:0] k, input logic last);
		logic [127:0] t, m;
		for (int c = 0; c < 4; c++)
			for (int i = 0; i < 4; i++)
				t[127-8*(4*c+i) -: 8] = SBOX[get_byte(s, 4*((c+i)&3)+i)];
		for (int c = 0; c < 4; c++)
			m[127-32*c -: 32] = mix_col(t[127-32*c -: 32]);
		return (last ? t : m) ^ k;
	endfunction

	function automatic logic [127:0] dec_round(input logic [127:0] s,
			input logic [127:0] k, input logic last);
		logic [127:0] t, m;
		for (int c = 0; c < 4; c++)
			for (int i = 0; i < 4; i++)
				t[127-8*(4*((c+i)&3)+i) -: 8] = INV_SBOX[get_byte(s, 4*c+i)];
		t = t ^ k;
		for (int c = 0; c < 4; c++)
			m[127-32*c -: 32] = inv_mix_col(t[127-32*c -: 32]);
		return last ? t : m;
	endfunction

	// next four key words from the eight previous ones (oldest on top)
	function automatic logic [127:0] expand_step(input logic [255:0] win,
			input logic rot, input logic [7:0] rcon);
		logic [31:0] t, n0, n1, n2, n3;
		t = win[31:0];
		if (rot)
			t = {SBOX[t[23:16]] ^ rcon, SBOX[t[15:8]], SBOX[t[7:0]], SBOX[t[31:24]]};
		else
			t = {SBOX[t[31:24]], SBOX[t[23:16]], SBOX[t[15:8]], SBOX[t[7:0]]};
		n0 = win[255:224] ^ t;
		n1 = win[223:192] ^ n0;
		n2 = win[191:160] ^ n1;
		n3 = win[159:128] ^ n2;
		return {n0, n1, n2, n3};
	endfunction

endpackage

// ===== design/aes_ctrl.sv =====
// ---------------------------------------------------------------------------
// aes_ctrl
// Sequencer: key expansion, round sequencing and handshakes.
// ---------------------------------------------------------------------------
module aes_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	input  aes_pkg::stat_t    stat,
	output aes_pkg::cmd_t     cmd
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_EXPAND = 3'd1;
	localparam logic [2:0] ST_ADDK   = 3'd2;
	localparam logic [2:0] ST_ROUND  = 3'd3;
	localparam logic [2:0] ST_DONE   = 3'd4;

	logic [2:0] state_q, state_d;
	logic [3:0] cnt_q, cnt_d;
	logic [3:0] kidx_q, kidx_d, nxt;
	logic       ready_q, ready_d;
	logic       outv_q, outv_d;
	logic       last;

	assign nxt  = stat.decrypt ? kidx_q - 4'd1 : kidx_q + 4'd1;
	assign last = stat.decrypt ? (kidx_q == 4'd0) : (kidx_q == aes_pkg::LAST_KEY);

	always_comb begin
		cmd        = '0;
		cmd.op     = aes_pkg::OP_NONE;
		cmd.idx    = cnt_q;
		cmd.rd_idx = kidx_q;
		state_d    = state_q;
		cnt_d      = cnt_q;
		kidx_d     = kidx_q;
		ready_d    = ready_q;
		outv_d     = outv_q && out_stall;
		case (state_q)
			ST_IDLE: begin
				if (!ready_q) begin
					state_d = ST_EXPAND;
					cnt_d   = 4'd0;
				end else if (in_valid) begin
					cmd.op     = aes_pkg::OP_LOAD;
					cmd.rd_en  = 1'b1;
					cmd.rd_idx = stat.decrypt ? aes_pkg::LAST_KEY : 4'd0;
					kidx_d     = cmd.rd_idx;
					state_d    = ST_ADDK;
				end
			end
			ST_EXPAND: begin
				cmd.op = aes_pkg::OP_EXPAND;
				if (cnt_q == aes_pkg::LAST_KEY) begin
					ready_d = 1'b1;
					state_d = ST_IDLE;
				end else begin
					cnt_d = cnt_q + 4'd1;
				end
			end
			ST_ADDK: begin
				cmd.op     = aes_pkg::OP_ADDKEY;
				cmd.rd_en  = 1'b1;
				cmd.rd_idx = nxt;
				kidx_d     = nxt;
				state_d    = ST_ROUND;
			end
			ST_ROUND: begin
				cmd.op   = aes_pkg::OP_ROUND;
				cmd.last = last;
				if (last) begin
					state_d = ST_DONE;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_idx = nxt;
					kidx_d     = nxt;
				end
			end
			ST_DONE: begin
				if (!outv_q || !out_stall) begin
					cmd.op  = aes_pkg::OP_FINISH;
					outv_d  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		// new key: drop the schedule, restart expansion from idle
		if (stat.key_wr) begin
			ready_d = 1'b0;
			if (state_q == ST_EXPAND)
				state_d = ST_IDLE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= 4'd0;
			kidx_q  <= 4'd0;
			ready_q <= 1'b0;
			outv_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			kidx_q  <= kidx_d;
			ready_q <= ready_d;
			outv_q  <= outv_d;
		end
	end

	assign in_stall  = !(state_q == ST_IDLE && ready_q);
	assign out_valid = outv_q;

endmodule

// ===== design/aes_dp.sv =====
// ---------------------------------------------------------------------------
// aes_dp
// Datapath: config registers, round key memory, key schedule, round
// unit, CBC chain and output register.
// ---------------------------------------------------------------------------
module aes_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [2:0]        cfg_index,
	input  logic [63:0]       cfg_data,
	input  logic [63:0]       block_bytes_0_7,
	input  logic [63:0]       block_bytes_8_15,
	input  logic              restart_chain,
	input  aes_pkg::cmd_t     cmd,
	output aes_pkg::stat_t    stat,
	output logic [63:0]       result_bytes_0_7,
	output logic [63:0]       result_bytes_8_15
);

	logic [255:0] key_q;
	logic [127:0] iv_q;
	logic         dec_q;
	logic [127:0] chain_q;
	logic [127:0] st_q, blk_q, out_q, rk_q;
	logic [255:0] win_q;
	logic [7:0]   rcon_q;
	logic [127:0] rk_mem [aes_pkg::NUM_KEYS];
	logic [127:0] nk, wr_data, blk, ch;

	assign blk = {block_bytes_0_7, block_bytes_8_15};
	assign ch  = restart_chain ? iv_q : chain_q;
	assign nk  = aes_pkg::expand_step(win_q, !cmd.idx[0], rcon_q);

	always_comb begin
		case (cmd.idx)
			4'd0:    wr_data = key_q[255:128];
			4'd1:    wr_data = win_q[127:0];
			default: wr_data = nk;
		endcase
	end

	// config registers and chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q   <= '0;
			iv_q    <= '0;
			dec_q   <= 1'b0;
			chain_q <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					aes_pkg::CFG_KEY0: key_q[255:192] <= cfg_data;
					aes_pkg::CFG_KEY1: key_q[191:128] <= cfg_data;
					aes_pkg::CFG_KEY2: key_q[127:64]  <= cfg_data;
					aes_pkg::CFG_KEY3: key_q[63:0]    <= cfg_data;
					aes_pkg::CFG_IV0:  iv_q[127:64]   <= cfg_data;
					aes_pkg::CFG_IV1:  iv_q[63:0]     <= cfg_data;
					aes_pkg::CFG_DEC:  dec_q          <= cfg_data[0];
					default: ;
				endcase
			end
			if (cmd.op == aes_pkg::OP_LOAD)
				chain_q <= ch;
			else if (cmd.op == aes_pkg::OP_FINISH)
				chain_q <= dec_q ? blk_q : st_q;
		end
	end

	// round key memory
	always_ff @(posedge clk) begin
		if (cmd.op == aes_pkg::OP_EXPAND)
			rk_mem[cmd.idx] <= wr_data;
		if (cmd.rd_en)
			rk_q <= rk_mem[cmd.rd_idx];
	end

	// key schedule window and round state
	always_ff @(posedge clk) begin
		case (cmd.op)
			aes_pkg::OP_EXPAND: begin
				if (cmd.idx == 4'd0) begin
					win_q  <= key_q;
					rcon_q <= 8'h01;
				end else if (cmd.idx != 4'd1) begin
					win_q <= {win_q[127:0], nk};
					if (!cmd.idx[0])
						rcon_q <= aes_pkg::xtime(rcon_q);
				end
			end
			aes_pkg::OP_LOAD: begin
				blk_q <= blk;
				st_q  <= dec_q ? blk : blk ^ ch;
			end
			aes_pkg::OP_ADDKEY: st_q <= st_q ^ rk_q;
			aes_pkg::OP_ROUND: begin
				st_q <= dec_q ? aes_pkg::dec_round(st_q, rk_q, cmd.last)
				              : aes_pkg::enc_round(st_q, rk_q, cmd.last);
			end
			aes_pkg::OP_FINISH: out_q <= dec_q ? st_q ^ chain_q : st_q;
			default: ;
		endcase
	end

	assign stat.decrypt = dec_q;
	assign stat.key_wr  = cfg_we && (cfg_index == aes_pkg::CFG_KEY0 ||
		cfg_index == aes_pkg::CFG_KEY1 || cfg_index == aes_pkg::CFG_KEY2 ||
		cfg_index == aes_pkg::CFG_KEY3);

	assign result_bytes_0_7  = out_q[127:64];
	assign result_bytes_8_15 = out_q[63:0];

endmodule

// ===== design/aes256_cbc_cipher_core.sv =====
// ---------------------------------------------------------------------------
// aes256_cbc_cipher_core
// AES-256 CBC encrypt/decrypt core, one 16-byte block per transfer.
// ---------------------------------------------------------------------------
// Usage:
//  - Config: cfg_we/cfg_index/cfg_data write key words 0..3, IV words 4..5
//    and the direction (index 6, bit 0). Write only while the core is idle.
//  - A key write clears the key schedule; the core then expands 15 round
//    keys into its key RAM (one key per cycle) and holds in_stall high
//    until done.
//  - Input: a transfer on in_valid/!in_stall carries one block and the
//    restart_chain flag (chain reloads from the IV for that block).
//  - Each block passes through load, initial key add and 14 rounds from
//    the shared round unit before out_valid rises.
//  - One block at a time, each after the last result is registered; the CBC chain serializes blocks.
//  - The result sits in an output register; a stalled receiver holds it,
//    and the next block is processed meanwhile, waiting at the end only if
//    the previous result is still untaken.
//  - Reset: config, chain and control clear; key expansion runs after reset.
// ---------------------------------------------------------------------------
module aes256_cbc_cipher_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [63:0] block_bytes_0_7,
	input  logic [63:0] block_bytes_8_15,
	input  logic        restart_chain,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] result_bytes_0_7,
	output logic [63:0] result_bytes_8_15
);

	aes_pkg::cmd_t  cmd;   // sequencer -> datapath
	aes_pkg::stat_t stat;  // datapath -> sequencer

	aes_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	aes_dp u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_we            (cfg_we),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.block_bytes_0_7   (block_bytes_0_7),
		.block_bytes_8_15  (block_bytes_8_15),
		.restart_chain     (restart_chain),
		.cmd               (cmd),
		.stat              (stat),
		.result_bytes_0_7  (result_bytes_0_7),
		.result_bytes_8_15 (result_bytes_8_15)
	);

endmodule

// ===== design/aes_checker.sv =====
// ---------------------------------------------------------------------------
// aes_checker
// Port-level checks for the AES-256 CBC core, bound to the top level.
// ---------------------------------------------------------------------------
module aes_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        cfg_we,
	input logic [2:0]  cfg_index,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [63:0] result_bytes_0_7
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(result_bytes_0_7))
		else $error("stalled result changed");

	// one block at a time: no transfer right after a transfer
	a_in_busy1: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken while busy");

	a_in_busy2: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |-> ##2 in_stall)
		else $error("input taken during rounds");

	// key write forces a new schedule before the next block
	a_key_stall: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we && (cfg_index == aes_pkg::CFG_KEY0 || cfg_index == aes_pkg::CFG_KEY1 ||
		cfg_index == aes_pkg::CFG_KEY2 || cfg_index == aes_pkg::CFG_KEY3) |=> in_stall)
		else $error("input open after key write");

endmodule

bind aes256_cbc_cipher_core aes_checker u_aes_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.cfg_we           (cfg_we),
	.cfg_index        (cfg_index),
	.in_valid         (in_valid),
	.in_stall         (in_stall),
	.out_valid        (out_valid),
	.out_stall        (out_stall),
	.result_bytes_0_7 (result_bytes_0_7)
);

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the AES-256 CBC core: a local cipher model predicts
// every output block; directed vectors, then random messages under varied
// flow control and several key/IV/direction settings.
// ---------------------------------------------------------------------------
module tb_top;

	typedef struct {
		logic [63:0] hi;
		logic [63:0] lo;
		logic        restart;
	} blk_t;

	typedef struct {
		logic [63:0] hi;
		logic [63:0] lo;
	} res_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [63:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [63:0] block_bytes_0_7 = '0;
	logic [63:0] block_bytes_8_15 = '0;
	logic        restart_chain = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [63:0] result_bytes_0_7;
	logic [63:0] result_bytes_8_15;

	aes256_cbc_cipher_core i_dut (.*);

	always #5 clk = ~clk;

	// predictor state
	logic [63:0]  key_words [4];
	logic [63:0]  iv_words [2];
	logic         dec_sel;
	logic [127:0] sched [15];
	logic         sched_valid;
	logic [127:0] chain;

	blk_t blk_queue [$];
	res_t cipher_queue [$];

	int  send_idle_pct = 0;
	int  recv_idle_pct = 0;
	int  hold_cycles = 0;
	int  quiet_cycles = 0;
	int  fail_count = 0;

	// ---- local cipher model ----
	function automatic logic [7:0] gmul(logic [7:0] a, logic [7:0] b);
		logic [7:0] p;
		p = 0;
		for (int i = 0; i < 8; i++) begin
			if (b[i]) p ^= a;
			a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
		end
		return p;
	endfunction

	function automatic logic [7:0] ginv(logic [7:0] a);
		logic [7:0] r, base;
		r = 8'h01;
		base = a;
		for (int e = 0; e < 8; e++) begin
			if (e != 0) r = gmul(r, base);
			base = gmul(base, base);
		end
		return r; // a^254 = product of a^(2^1..2^7)
	endfunction

	function automatic logic [7:0] rotb(logic [7:0] x, int n);
		return (x << n) | (x >> (8 - n));
	endfunction

	function automatic logic [7:0] sub_fwd(logic [7:0] x);
		logic [7:0] b;
		b = ginv(x);
		return b ^ rotb(b, 1) ^ rotb(b, 2) ^ rotb(b, 3) ^ rotb(b, 4) ^ 8'h63;
	endfunction

	function automatic logic [7:0] sub_inv(logic [7:0] s);
		return ginv(rotb(s, 1) ^ rotb(s, 3) ^ rotb(s, 6) ^ 8'h05);
	endfunction

	function automatic logic [7:0] byte_of(logic [127:0] s, int n);
		return s[127-8*n -: 8];
	endfunction

	task automatic build_schedule();
		logic [31:0] w [60];
		logic [31:0] t;
		logic [7:0]  rc;
		rc = 8'h01;
		for (int i = 0; i < 8; i++) w[i] = key_words[i/2][63-32*(i%2) -: 32];
		for (int i = 8; i < 60; i++) begin
			t = w[i-1];
			if (i % 8 == 0) begin
				t = {sub_fwd(t[23:16]) ^ rc, sub_fwd(t[15:8]), sub_fwd(t[7:0]),
					sub_fwd(t[31:24])};
				rc = gmul(rc, 8'h02);
			end else if (i % 8 == 4) begin
				t = {sub_fwd(t[31:24]), sub_fwd(t[23:16]), sub_fwd(t[15:8]),
					sub_fwd(t[7:0])};
			end
			w[i] = w[i-8] ^ t;
		end
		for (int r = 0; r < 15; r++) sched[r] = {w[4*r], w[4*r+1], w[4*r+2], w[4*r+3]};
		sched_valid = 1'b1;
	endtask

	function automatic logic [127:0] cipher_fwd(logic [127:0] s);
		logic [127:0] t;
		logic [7:0]   a0, a1, a2, a3;
		s ^= sched[0];
		for (int r = 1; r <= 14; r++) begin
			for (int c = 0; c < 4; c++)
				for (int i = 0; i < 4; i++)
					t[127-8*(4*c+i) -: 8] = sub_fwd(byte_of(s, 4*((c+i)%4)+i));
			s = t;
			if (r != 14)
				for (int c = 0; c < 4; c++) begin
					a0 = byte_of(t, 4*c); a1 = byte_of(t, 4*c+1);
					a2 = byte_of(t, 4*c+2); a3 = byte_of(t, 4*c+3);
					s[127-32*c -: 32] = {gmul(a0,2)^gmul(a1,3)^a2^a3,
						a0^gmul(a1,2)^gmul(a2,3)^a3, a0^a1^gmul(a2,2)^gmul(a3,3),
						gmul(a0,3)^a1^a2^gmul(a3,2)};
				end
			s ^= sched[r];
		end
		return s;
	endfunction

	function automatic logic [127:0] cipher_inv(logic [127:0] s);
		logic [127:0] t;
		logic [7:0]   a0, a1, a2, a3;
		s ^= sched[14];
		for (int r = 13; r >= 0; r--) begin
			for (int c = 0; c < 4; c++)
				for (int i = 0; i < 4; i++)
					t[127-8*(4*((c+i)%4)+i) -: 8] = sub_inv(byte_of(s, 4*c+i));
			s = t ^ sched[r];
			t = s;
			if (r != 0)
				for (int c = 0; c < 4; c++) begin
					a0 = byte_of(t, 4*c); a1 = byte_of(t, 4*c+1);
					a2 = byte_of(t, 4*c+2); a3 = byte_of(t, 4*c+3);
					s[127-32*c -: 32] = {
						gmul(a0,14)^gmul(a1,11)^gmul(a2,13)^gmul(a3,9),
						gmul(a0,9)^gmul(a1,14)^gmul(a2,11)^gmul(a3,13),
						gmul(a0,13)^gmul(a1,9)^gmul(a2,14)^gmul(a3,11),
						gmul(a0,11)^gmul(a1,13)^gmul(a2,9)^gmul(a3,14)};
				end
		end
		return s;
	endfunction

	// one accepted block -> one expected result
	task automatic predict_cbc(blk_t b);
		logic [127:0] x, y;
		res_t r;
		if (!sched_valid) build_schedule();
		if (b.restart) chain = {iv_words[0], iv_words[1]};
		x = {b.hi, b.lo};
		if (dec_sel) begin
			y = cipher_inv(x) ^ chain;
			chain = x;
		end else begin
			y = cipher_fwd(x ^ chain);
			chain = y;
		end
		r.hi = y[127:64];
		r.lo = y[63:0];
		cipher_queue.push_back(r);
	endtask

	// ---- config writes (core idle) ----
	task automatic write_reg(logic [2:0] idx, logic [63:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx <= aes_pkg::CFG_KEY3) begin
			key_words[idx] = val;
			sched_valid = 1'b0;
		end else if (idx == aes_pkg::CFG_IV0 || idx == aes_pkg::CFG_IV1) begin
			iv_words[idx - aes_pkg::CFG_IV0] = val;
		end else if (idx == aes_pkg::CFG_DEC) begin
			dec_sel = val[0];
		end
	endtask

	task automatic setup_all(logic [255:0] k, logic [127:0] iv, logic d);
		for (int i = 0; i < 4; i++)
			write_reg(3'(aes_pkg::CFG_KEY0 + i), k[255-64*i -: 64]);
		write_reg(aes_pkg::CFG_IV0, iv[127:64]);
		write_reg(aes_pkg::CFG_IV1, iv[63:0]);
		write_reg(aes_pkg::CFG_DEC, {63'b0, d});
	endtask

	task automatic drain();
		wait (blk_queue.size() == 0 && !in_valid);
		wait (cipher_queue.size() == 0);
		repeat (40) @(posedge clk);
	endtask

	function automatic logic [63:0] rnd64();
		return {$urandom, $urandom};
	endfunction

	task automatic queue_blk(logic [63:0] h, logic [63:0] l, logic rs);
		blk_t b;
		b.hi = h; b.lo = l; b.restart = rs;
		blk_queue.push_back(b);
	endtask

	// random CBC messages with random content; now and then a chain restart mid-message
	task automatic queue_messages(int n);
		int len;
		while (n > 0) begin
			len = $urandom_range(1, 12);
			for (int i = 0; i < len && n > 0; i++, n--)
				queue_blk(rnd64(), rnd64(), i == 0 ? 1'b1 : ($urandom_range(0, 30) == 0));
		end
	endtask

	// ---- driver ----
	always @(posedge clk) begin
		if (in_valid && !in_stall) begin
			predict_cbc(blk_queue.pop_front());
		end
		if (!(in_valid && in_stall)) begin
			if (blk_queue.size() > (in_valid && !in_stall ? 0 : 0) &&
					$urandom_range(0, 99) >= send_idle_pct) begin
				in_valid <= 1'b1;
				block_bytes_0_7 <= blk_queue[0].hi;
				block_bytes_8_15 <= blk_queue[0].lo;
				restart_chain <= blk_queue[0].restart;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// ---- receiver stall and long hold-off ----
	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
		end
	end

	// ---- monitor ----
	always @(posedge clk) begin
		res_t e;
		if (out_valid && !out_stall) begin
			if (cipher_queue.size() == 0) begin
				$error("unexpected result %h %h", result_bytes_0_7, result_bytes_8_15);
				fail_count++;
			end else begin
				e = cipher_queue.pop_front();
				if (result_bytes_0_7 !== e.hi) begin
					$error("result_bytes_0_7 exp %h got %h", e.hi, result_bytes_0_7);
					fail_count++;
				end
				if (result_bytes_8_15 !== e.lo) begin
					$error("result_bytes_8_15 exp %h got %h", e.lo, result_bytes_8_15);
					fail_count++;
				end
			end
		end
	end

	// ---- watchdog: cycles with no transfer on either side ----
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > 5000) begin
			$display("aes256_cbc_cipher_core test failed");
			$finish;
		end
	end

	initial begin
		for (int i = 0; i < 4; i++) key_words[i] = '0;
		iv_words[0] = '0; iv_words[1] = '0;
		dec_sel = 1'b0;
		sched_valid = 1'b0;
		chain = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// reset config, no restart: zero chain used as is
		queue_blk('0, '0, 1'b0);
		queue_blk('1, '1, 1'b0);
		drain();

		// FIPS-197 AES-256 key, known plaintext, all-zero IV
		setup_all(256'h000102030405060708090a0b0c0d0e0f101112131415161718191a1b1c1d1e1f,
			'0, 1'b0);
		queue_blk(64'h0011223344556677, 64'h8899aabbccddeeff, 1'b1);
		queue_blk(64'haaaaaaaaaaaaaaaa, 64'h5555555555555555, 1'b0);
		drain();
		// decrypt the FIPS ciphertext, then switch direction mid-message
		write_reg(aes_pkg::CFG_DEC, 64'd1);
		queue_blk(64'h8ea2b7ca516745bf, 64'heafc49904b496089, 1'b1);
		queue_blk('1, '0, 1'b0);
		drain();
		write_reg(aes_pkg::CFG_DEC, 64'd0);
		queue_blk('0, '1, 1'b0);
		drain();
		// IV write alone does not act until a restart
		write_reg(aes_pkg::CFG_IV0, '1);
		write_reg(aes_pkg::CFG_IV1, 64'h0123456789abcdef);
		queue_blk(rnd64(), rnd64(), 1'b0);
		queue_blk(rnd64(), rnd64(), 1'b1);
		drain();
		// all-ones key and IV, decrypt direction
		setup_all('1, '1, 1'b1);
		queue_blk('1, '1, 1'b1);
		queue_blk('0, '0, 1'b0);
		drain();
		// single key word change forces re-expansion
		write_reg(aes_pkg::CFG_KEY2, 64'h8000000000000001);
		queue_blk(rnd64(), rnd64(), 1'b1);
		drain();

		// random phases: sender/receiver idle mixes, several settings
		for (int ph = 0; ph < 6; ph++) begin
			setup_all({rnd64(), rnd64(), rnd64(), rnd64()}, {rnd64(), rnd64()},
				ph[0]);
			case (ph % 3)
				0: begin send_idle_pct = 24; recv_idle_pct = 63; end
				1: begin send_idle_pct = 63; recv_idle_pct = 24; end
				default: begin send_idle_pct = 0; recv_idle_pct = 0; end
			endcase
			if (ph == 2) hold_cycles = 300;
			queue_messages(255);
			drain();
		end
		send_idle_pct = 0;
		recv_idle_pct = 0;
		repeat (40) @(posedge clk);
		if (fail_count == 0 && cipher_queue.size() == 0)
			$display("aes256_cbc_cipher_core test passed");
		else
			$display("aes256_cbc_cipher_core test failed");
		$finish;
	end
endmodule
